### design/foq_pkg.sv
// ----------------------------------------------------------------------------
// foq_pkg: shared definitions of the fuel-ordered holding queue
// Opcodes, status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package foq_pkg;

  localparam int ID_W   = 8;
  localparam int FUEL_W = 16;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [FUEL_W-1:0] fuel;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHECK,
    S_INS_CMP,
    S_POP_DATA,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input word
    logic decode;     // set the result status from opcode and fill level
    logic idx_load;   // start the insert scan at the tail
    logic idx_dec;    // move the scan one entry toward the front
    logic rd_en;      // issue a memory read
    logic rd_head;    // read the front entry instead of the one before idx
    logic wr_en;      // write the memory at the scan position
    logic wr_new;     // write the new entry instead of the shifted one
    logic count_inc;  // one more entry held
    logic pop_take;   // take the front entry into the result, advance head
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_insert;
    logic full;
    logic empty;
    logic idx_zero;
    logic rd_greater;
    logic out_free;
  } stat_t;

endpackage

### design/foq_ctrl.sv
// ----------------------------------------------------------------------------
// foq_ctrl: sequencer of the fuel-ordered holding queue
// Steps one item at a time through decode, the insertion scan or the pop,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module foq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  foq_pkg::stat_t stat_i,
  output foq_pkg::cmd_t  cmd_o
);

  foq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= foq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      foq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = foq_pkg::S_DECODE;
        end
      end
      foq_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (stat_i.op_insert) begin
          if (stat_i.full) begin
            state_d = foq_pkg::S_FINISH;
          end else begin
            cmd_o.idx_load = 1'b1;
            state_d        = foq_pkg::S_INS_CHECK;
          end
        end else begin
          if (stat_i.empty) begin
            state_d = foq_pkg::S_FINISH;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_head = 1'b1;
            state_d       = foq_pkg::S_POP_DATA;
          end
        end
      end
      foq_pkg::S_INS_CHECK: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_new    = 1'b1;
          cmd_o.count_inc = 1'b1;
          state_d         = foq_pkg::S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = foq_pkg::S_INS_CMP;
        end
      end
      foq_pkg::S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.rd_greater) begin
          cmd_o.idx_dec = 1'b1;
          state_d       = foq_pkg::S_INS_CHECK;
        end else begin
          cmd_o.wr_new    = 1'b1;
          cmd_o.count_inc = 1'b1;
          state_d         = foq_pkg::S_FINISH;
        end
      end
      foq_pkg::S_POP_DATA: begin
        cmd_o.pop_take = 1'b1;
        state_d        = foq_pkg::S_FINISH;
      end
      foq_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = foq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = foq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/foq_datapath.sv
// ----------------------------------------------------------------------------
// foq_datapath: storage and result path of the fuel-ordered holding queue
// Holds the entries in a ring memory sorted from head, the fill count, the
// scan index and the output register.
// ----------------------------------------------------------------------------
module foq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  foq_pkg::cmd_t               cmd_i,
  output foq_pkg::stat_t              stat_o,
  input  logic                        in_op_i,
  input  logic [foq_pkg::ID_W-1:0]    in_id_i,
  input  logic [foq_pkg::FUEL_W-1:0]  in_fuel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_popped_valid_o,
  output logic [foq_pkg::ID_W-1:0]    out_popped_id_o,
  output logic [foq_pkg::FUEL_W-1:0]  out_popped_fuel_o,
  output logic [foq_pkg::OCC_W-1:0]   out_occupancy_o,
  output logic [foq_pkg::STAT_W-1:0]  out_status_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  foq_pkg::entry_t mem_q [QUEUE_DEPTH];
  foq_pkg::entry_t rd_q;

  logic                        op_q;
  logic [foq_pkg::ID_W-1:0]    id_q;
  logic [foq_pkg::FUEL_W-1:0]  fuel_q;
  logic [PTR_W-1:0]            head_q, head_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            idx_prev;

  logic                        res_valid_q;
  logic [foq_pkg::ID_W-1:0]    res_id_q;
  logic [foq_pkg::FUEL_W-1:0]  res_fuel_q;
  logic [foq_pkg::STAT_W-1:0]  res_status_q;

  logic                        m_valid_q;
  logic                        m_pvalid_q;
  logic [foq_pkg::ID_W-1:0]    m_id_q;
  logic [foq_pkg::FUEL_W-1:0]  m_fuel_q;
  logic [foq_pkg::OCC_W-1:0]   m_occ_q;
  logic [foq_pkg::STAT_W-1:0]  m_status_q;

  logic [PTR_W-1:0]            wr_addr, rd_addr;
  foq_pkg::entry_t             wr_data;

  // Logical position behind head to physical address, with one wrap.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PTR_W-1:0];
  endfunction

  assign idx_prev = idx_q - CNT_W'(1);
  assign wr_addr  = phys(head_q, idx_q);
  assign rd_addr  = cmd_i.rd_head ? head_q : phys(head_q, idx_prev);
  assign wr_data  = cmd_i.wr_new ? foq_pkg::entry_t'{id: id_q, fuel: fuel_q} : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = count_q;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_prev;
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_take) begin
      count_d = count_q - CNT_W'(1);
      head_d  = (head_q == LAST_P) ? '0 : head_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_op_i;
      id_q   <= in_id_i;
      fuel_q <= in_fuel_i;
    end
    if (cmd_i.decode) begin
      res_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_fuel_q   <= '0;
      if (op_q == foq_pkg::OP_INSERT) begin
        res_status_q <= stat_o.full ? foq_pkg::STATUS_FULL : foq_pkg::STATUS_OK;
      end else begin
        res_status_q <= stat_o.empty ? foq_pkg::STATUS_EMPTY : foq_pkg::STATUS_OK;
      end
    end
    if (cmd_i.pop_take) begin
      res_valid_q <= 1'b1;
      res_id_q    <= rd_q.id;
      res_fuel_q  <= rd_q.fuel;
    end
    if (cmd_i.out_load) begin
      m_pvalid_q <= res_valid_q;
      m_id_q     <= res_id_q;
      m_fuel_q   <= res_fuel_q;
      m_occ_q    <= foq_pkg::OCC_W'(count_q);
      m_status_q <= res_status_q;
    end
  end

  assign stat_o.op_insert  = (op_q == foq_pkg::OP_INSERT);
  assign stat_o.full       = (count_q == DEPTH_C);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.rd_greater = (rd_q.fuel > fuel_q);
  assign stat_o.out_free   = !m_valid_q || out_ready_i;

  assign out_valid_o        = m_valid_q;
  assign out_popped_valid_o = m_pvalid_q;
  assign out_popped_id_o    = m_id_q;
  assign out_popped_fuel_o  = m_fuel_q;
  assign out_occupancy_o    = m_occ_q;
  assign out_status_o       = m_status_q;

endmodule

### design/fuel_ordered_holding_queue.sv
// ----------------------------------------------------------------------------
// fuel_ordered_holding_queue: bounded queue sorted by ascending fuel
// Insert places an aircraft behind every held entry of equal or lower fuel;
// pop returns the entry with the least fuel. One result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command per word: tuser bit 0 selects
//   insert (0) or pop (1), tdata carries the aircraft id and fuel key.
//   Each command yields exactly one output word with the popped entry (or
//   zeros), the occupancy after the command and a status code.
//   The queue is a ring memory read through a registered port; an insert
//   walks from the tail toward the front, moving one larger entry at a time.
//   A pop simply advances the head pointer. The next word is taken in the
//   cycle after the result enters the output register.
//   Reset empties the queue at once; memory contents need no clearing since
//   only held entries are ever read.
//   A stalled receiver holds the result in the output register; a following
//   command is still accepted and processed, and waits only to deliver.
// ----------------------------------------------------------------------------
module fuel_ordered_holding_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // aircraft_id[7:0], fuel_level[23:8]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // popped_valid[0], popped_id[8:1], popped_fuel[24:9], occupancy[29:25],
  // status[31:30]
  output logic [31:0] m_axis_tdata
);

  foq_pkg::cmd_t  cmd;
  foq_pkg::stat_t stat;

  logic                        popped_valid;
  logic [foq_pkg::ID_W-1:0]    popped_id;
  logic [foq_pkg::FUEL_W-1:0]  popped_fuel;
  logic [foq_pkg::OCC_W-1:0]   occupancy;
  logic [foq_pkg::STAT_W-1:0]  status;

  foq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  foq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_op_i            (s_axis_tuser[0]),
    .in_id_i            (s_axis_tdata[7:0]),
    .in_fuel_i          (s_axis_tdata[23:8]),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .out_popped_valid_o (popped_valid),
    .out_popped_id_o    (popped_id),
    .out_popped_fuel_o  (popped_fuel),
    .out_occupancy_o    (occupancy),
    .out_status_o       (status)
  );

  assign m_axis_tdata = {status, occupancy, popped_fuel, popped_id, popped_valid};

  // The controller never grows the queue past its depth.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.count_inc |-> !stat.full)
    else $error("insert committed into a full queue");

  // A result is only moved into the output register when it has room.
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while held");

  // A returned entry always carries the ok status.
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && popped_valid) |-> (status == foq_pkg::STATUS_OK))
    else $error("popped entry with error status");

  // After a word is accepted the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while first in progress");

endmodule

### verif/foq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foq_checker: result checker for the fuel-ordered holding queue
// Watches both stream channels, keeps its own sorted copy of the queue,
// works out the result word of every accepted command and compares it
// field by field with the words that leave the block.
// ----------------------------------------------------------------------------
module foq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // aircraft_id[7:0], fuel_level[23:8]
  input  logic [0:0]  s_tuser_i,   // opcode[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // popped_valid[0], popped_id[8:1], popped_fuel[24:9], occupancy[29:25],
  // status[31:30]
  input  logic [31:0] m_tdata_i,
  output int          errors_o,
  output int          pending_o
);

  // Declared from the top bit down, so it overlays the output word directly.
  typedef struct packed {
    logic [foq_pkg::STAT_W-1:0] status;
    logic [foq_pkg::OCC_W-1:0]  occupancy;
    logic [foq_pkg::FUEL_W-1:0] fuel;
    logic [foq_pkg::ID_W-1:0]   id;
    logic                       valid;
  } result_t;

  foq_pkg::entry_t held [QUEUE_DEPTH];
  int unsigned     held_count;
  result_t         due_results [$];

  // Applies one command to the shadow queue and returns its result word.
  function automatic result_t apply_command(input logic op,
                                            input foq_pkg::entry_t arrival);
    result_t     res;
    int unsigned slot;
    res = '0;
    res.status = foq_pkg::STATUS_OK;
    if (op == foq_pkg::OP_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = foq_pkg::STATUS_FULL;
      end else begin
        // Entries with a strictly larger key move back; equal keys stay ahead.
        slot = held_count;
        while (slot > 0 && held[slot-1].fuel > arrival.fuel) begin
          held[slot] = held[slot-1];
          slot--;
        end
        held[slot] = arrival;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = foq_pkg::STATUS_EMPTY;
      end else begin
        res.valid = 1'b1;
        res.id    = held[0].id;
        res.fuel  = held[0].fuel;
        for (int k = 1; k < held_count; k++) held[k-1] = held[k];
        held_count--;
      end
    end
    res.occupancy = foq_pkg::OCC_W'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t         want;
    result_t         got;
    foq_pkg::entry_t arrival;
    if (!rst_ni) begin
      held_count = 0;
      due_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // The output side is checked first: no command can finish in the
      // cycle it is accepted, so a word leaving now belongs to an older one.
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (due_results.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result word %h at %0t", m_tdata_i, $realtime);
          errors_o <= errors_o + 1;
        end else begin
          want = due_results.pop_front();
          if (got.valid !== want.valid || got.id !== want.id ||
              got.fuel !== want.fuel || got.occupancy !== want.occupancy ||
              got.status !== want.status) begin
            if (errors_o < 10) begin
              $display("result mismatch at %0t: expected valid=%0d id=%0d fuel=%0d",
                       $realtime, want.valid, want.id, want.fuel,
                       " occ=%0d status=%0d", want.occupancy, want.status);
              $display("  got valid=%0d id=%0d fuel=%0d occ=%0d status=%0d",
                       got.valid, got.id, got.fuel, got.occupancy, got.status);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        arrival.id   = s_tdata_i[foq_pkg::ID_W-1:0];
        arrival.fuel = s_tdata_i[foq_pkg::ID_W +: foq_pkg::FUEL_W];
        due_results.insert(due_results.size(), apply_command(s_tuser_i[0], arrival));
      end
      pending_o <= due_results.size();
    end
  end

endmodule

### verif/tb_fuel_ordered_holding_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuel_ordered_holding_queue: stimulus and verdict for the holding queue
// Sends a short directed run of inserts and pops through the extremes and
// the full and empty cases, then several hundred random commands with bursty
// input and a stalling receiver. Checking lives in foq_checker.
// ----------------------------------------------------------------------------
module tb_fuel_ordered_holding_queue;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 430;
  // Length of the one long receiver hold-off, in clock cycles. It is far
  // longer than any command takes, so the block fills its output register,
  // finishes the next command and then has to drop s_axis_tready.
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // aircraft_id[7:0], fuel_level[23:8]
  logic [0:0]  s_axis_tuser = '0;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // popped_valid[0], popped_id[8:1], popped_fuel[24:9], occupancy[29:25],
  // status[31:30]
  logic [31:0] m_axis_tdata;

  int          errors;
  int          pending;
  // Set once by the stimulus; the receiver then starts its long hold-off.
  logic        hold_req = 1'b0;
  // Words still to go in the current input burst before a gap is inserted.
  int unsigned burst_left = 0;

  always #10 clk_i = ~clk_i;

  fuel_ordered_holding_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  foq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Offers one command word and returns at the falling edge after it was
  // taken. Inside a burst tvalid simply stays high with new data; at the end
  // of a burst it drops for a random gap and a new burst length is drawn.
  task automatic offer_word(input logic op, input logic [foq_pkg::ID_W-1:0] id,
                            input logic [foq_pkg::FUEL_W-1:0] fuel);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {fuel, id};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Stops sending and waits until every outstanding result has arrived.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int unsigned insert_pct;
    int unsigned phase_left;
    logic        op;
    logic [foq_pkg::ID_W-1:0]   id;
    logic [foq_pkg::FUEL_W-1:0] fuel;
    insert_pct = 50;
    phase_left = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A pop on the empty queue comes first, then inserts at
    // the key and id extremes and a group of equal keys, which must leave in
    // arrival order.
    offer_word(foq_pkg::OP_POP, 8'h5A, 16'h1234);
    offer_word(foq_pkg::OP_INSERT, 8'h00, 16'hFFFF);
    offer_word(foq_pkg::OP_INSERT, 8'hFF, 16'h0000);
    offer_word(foq_pkg::OP_INSERT, 8'h01, 16'd100);
    offer_word(foq_pkg::OP_INSERT, 8'h02, 16'd100);
    offer_word(foq_pkg::OP_INSERT, 8'h03, 16'd100);
    offer_word(foq_pkg::OP_INSERT, 8'h04, 16'd50);
    offer_word(foq_pkg::OP_POP, 8'h00, 16'h0000);
    // Fill the queue to the brim with a mix of keys, some of them equal to
    // entries already held, then try one more insert, which has to be
    // dropped with the full status.
    for (int k = 0; k < 11; k++)
      offer_word(foq_pkg::OP_INSERT, 8'(8'h10 + k), 16'((k * 37) % 160));
    offer_word(foq_pkg::OP_INSERT, 8'hAA, 16'h0001);
    offer_word(foq_pkg::OP_POP, 8'hFF, 16'hFFFF);
    offer_word(foq_pkg::OP_POP, 8'h00, 16'h0000);
    drain();

    // Random part. The insert share changes in phases, so the queue swings
    // between full and empty instead of hovering at a middle fill level.
    // Keys come often from a narrow range to create ties.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 20;
          default: insert_pct = 55;
        endcase
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      if (n == 150) hold_req = 1'b1;
      if (n == 300) drain();
      op = ($urandom_range(0, 99) < insert_pct) ? foq_pkg::OP_INSERT : foq_pkg::OP_POP;
      id = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:          fuel = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        1, 2, 3, 4: fuel = 16'($urandom_range(0, 7));
        default:    fuel = 16'($urandom_range(0, 65535));
      endcase
      offer_word(op, id, fuel);
    end

    drain();
    // Let any stray word the block might still emit show up in the checker.
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver. It runs through spans of different stall patterns: always
  // ready, random, mostly stalled and alternating. Once the stimulus asks
  // for it, it holds tready low for a long stretch counted here.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    bit          held_off;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held_off) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 60);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = 1'($urandom_range(0, 1));
          2:       m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
design/foq_pkg.sv
design/foq_ctrl.sv
design/foq_datapath.sv
design/fuel_ordered_holding_queue.sv
verif/foq_checker.sv
verif/tb_fuel_ordered_holding_queue.sv
